[design/rbb_pkg.sv]
// Shared types, codes and constant functions for the rotated box bounds block.
// Holds the item structs, axis and quadrant codes, and the sine/cosine table builder.
// No dependencies.
`default_nettype none

package rbb_pkg;

    localparam int ANGLE_STEPS_LOG2_DEF = 12;

    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;
    localparam logic [1:0] AXIS_Z    = 2'd3;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [63:0] ONE_Q60      = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PI_Q60       = 64'h3243_F6A8_885A_308D;
    localparam int          SERIES_TERMS = 14;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [15:0] trig_t;
    typedef logic signed [47:0] prod_t;

    typedef struct packed {
        coord_t     x_low;
        coord_t     x_high;
        coord_t     y_low;
        coord_t     y_high;
        coord_t     z_low;
        coord_t     z_high;
        logic [1:0] rot_axis;
        logic [15:0] rot_angle;
    } box_t;

    typedef struct packed {
        coord_t out_x_low;
        coord_t out_x_high;
        coord_t out_y_low;
        coord_t out_y_high;
        coord_t out_z_low;
        coord_t out_z_high;
    } bounds_t;

    typedef struct packed {
        coord_t a_lo;
        coord_t a_hi;
        coord_t b_lo;
        coord_t b_hi;
        coord_t t_lo;
        coord_t t_hi;
    } raw_t;

    typedef struct packed {
        logic [1:0]   axis;
        raw_t         raw;
        coord_t [3:0] na;
        coord_t [3:0] nb;
    } corner_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a0;
        logic [63:0] a1;
        logic [63:0] b0;
        logic [63:0] b1;
        logic [63:0] lo;
        logic [63:0] mid;
        logic [63:0] hi;
        logic [63:0] t;
        logic [63:0] upper;
        a0 = {32'd0, a[31:0]};
        a1 = {32'd0, a[63:32]};
        b0 = {32'd0, b[31:0]};
        b1 = {32'd0, b[63:32]};
        lo = a0 * b0;
        mid = a1 * b0 + a0 * b1;
        hi = a1 * b1;
        t = (lo >> 32) + {32'd0, mid[31:0]};
        upper = hi + (mid >> 32) + (t >> 32);
        return (upper << 4) | ({32'd0, t[31:0]} >> 28);
    endfunction

    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [63:0] series_q60(input logic [63:0] x,
                                                      input logic want_sin);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        div;
        logic signed [63:0] sum;
        x2 = mul_q60(x, x);
        term = want_sin ? x : ONE_Q60;
        sum = $signed(term);
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            div = want_sin ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
            term = div_u64(mul_q60(term, x2), div);
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end
            else begin
                sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    function automatic logic [14:0] scale_round(input logic signed [63:0] v);
        logic signed [63:0] c;
        logic [63:0]        u;
        logic [63:0]        r;
        c = v;
        if (c < 0) begin
            c = 64'sd0;
        end
        if (c > $signed(ONE_Q60)) begin
            c = $signed(ONE_Q60);
        end
        u = $unsigned(c) >> 20;
        r = (u * 64'd32767 + (64'd1 << 39)) >> 40;
        return r[14:0];
    endfunction

    function automatic logic [14:0] trig_entry(input logic [63:0] rem, input int steps_log2,
                                               input logic want_sin);
        logic [63:0] theta;
        theta = mul_q60(PI_Q60, rem << (61 - steps_log2));
        return scale_round(series_q60(theta, want_sin));
    endfunction

    function automatic coord_t shift_sat(input logic signed [48:0] v);
        logic signed [48:0] sh;
        sh = v >>> 15;
        if (sh > 49'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (sh < -49'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return sh[31:0];
    endfunction

endpackage

`default_nettype wire

[design/rotated_box_bounds.sv]
// Top level of the rotated box bounds block: stage valids, stall chain and assertions.
// Instantiates rbb_trig_rom, rbb_rotate and rbb_bounds; uses rbb_pkg.
//
// One box item per clock while bounds_stall is low; each item passes, in order:
// sine/cosine table read, quadrant fold and corner selection, the eight 16x32 products,
// per-corner sum with floor shift and saturation, then min/max and output register.
// Each stage holds only while the one after it is full and stalled, so bubbles close
// up and input is taken whenever any stage is free. The table holds 2^(ANGLE_STEPS_LOG2-2)
// sine/cosine pairs, fixed at elaboration; no clearing pass after reset.
`default_nettype none

module rotated_box_bounds #(
    parameter int ANGLE_STEPS_LOG2 = rbb_pkg::ANGLE_STEPS_LOG2_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             box_valid,
    output logic                  box_stall,
    input  wire rbb_pkg::box_t    box,
    output logic                  bounds_valid,
    input  wire logic             bounds_stall,
    output rbb_pkg::bounds_t      bounds
);
    import rbb_pkg::*;

    localparam int AW = ANGLE_STEPS_LOG2 - 2;

    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        v4_reg;
    logic        v5_reg;
    logic        en1;
    logic        en5;
    adv_t        adv;
    box_t        box1_reg;
    logic [14:0] sin_val;
    logic [14:0] cos_val;
    corner_t     rot;

    assign en5    = !v5_reg || !bounds_stall;
    assign adv.s4 = !v4_reg || en5;
    assign adv.s3 = !v3_reg || adv.s4;
    assign adv.s2 = !v2_reg || adv.s3;
    assign en1    = !v1_reg || adv.s2;

    assign box_stall    = !en1;
    assign bounds_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else begin
            if (en1) begin
                v1_reg <= box_valid;
            end
            if (adv.s2) begin
                v2_reg <= v1_reg;
            end
            if (adv.s3) begin
                v3_reg <= v2_reg;
            end
            if (adv.s4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en1) begin
            box1_reg <= box;
        end
    end

    rbb_trig_rom #(
        .STEPS_LOG2(ANGLE_STEPS_LOG2)
    ) u_rom (
        .clk    (clk),
        .en     (en1),
        .addr   (box.rot_angle[13 -: AW]),
        .sin_val(sin_val),
        .cos_val(cos_val)
    );

    rbb_rotate u_rotate (
        .clk    (clk),
        .adv    (adv),
        .box    (box1_reg),
        .sin_val(sin_val),
        .cos_val(cos_val),
        .rot    (rot)
    );

    rbb_bounds u_bounds (
        .clk   (clk),
        .en    (en5),
        .rot   (rot),
        .bounds(bounds)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        box_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg))
        else $error("input held while a stage is free");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && en5) |=> bounds_valid)
        else $error("item lost between last two stages");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (bounds_valid && !bounds_stall && !v4_reg) |=> !bounds_valid)
        else $error("result item repeated");

endmodule

`default_nettype wire

[design/rbb_trig_rom.sv]
// Quarter-turn sine and cosine table with a registered read.
// Built at elaboration from the series functions in rbb_pkg.
`default_nettype none

module rbb_trig_rom #(
    parameter int STEPS_LOG2 = rbb_pkg::ANGLE_STEPS_LOG2_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [STEPS_LOG2-3:0] addr,
    output logic [14:0]                sin_val,
    output logic [14:0]                cos_val
);
    import rbb_pkg::*;

    localparam int AW    = STEPS_LOG2 - 2;
    localparam int DEPTH = 1 << AW;

    logic [29:0] rom [DEPTH];
    logic [29:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_rom
        localparam logic [14:0] SIN_V = trig_entry(64'(i), STEPS_LOG2, 1'b1);
        localparam logic [14:0] COS_V = trig_entry(64'(i), STEPS_LOG2, 1'b0);
        assign rom[i] = {SIN_V, COS_V};
    end

    always_ff @(posedge clk) begin
        if (en) begin
            data_reg <= rom[addr];
        end
    end

    assign sin_val = data_reg[29:15];
    assign cos_val = data_reg[14:0];

endmodule

`default_nettype wire

[design/rbb_rotate.sv]
// Rotation datapath: quadrant fold, products, and per-corner sum with shift and saturate.
// Three register stages; uses rbb_pkg types and shift_sat.
`default_nettype none

module rbb_rotate (
    input  wire logic           clk,
    input  wire rbb_pkg::adv_t  adv,
    input  wire rbb_pkg::box_t  box,
    input  wire logic [14:0]    sin_val,
    input  wire logic [14:0]    cos_val,
    output rbb_pkg::corner_t    rot
);
    import rbb_pkg::*;

    trig_t      st;
    trig_t      ct;
    trig_t      s_next;
    trig_t      c_next;
    raw_t       raw_next;

    logic [1:0] axis2_reg;
    trig_t      c2_reg;
    trig_t      s2_reg;
    raw_t       raw2_reg;

    logic [1:0] axis3_reg;
    raw_t       raw3_reg;
    prod_t      ca_reg [2];
    prod_t      sa_reg [2];
    prod_t      cb_reg [2];
    prod_t      sb_reg [2];

    corner_t    rot_next;
    corner_t    rot_reg;

    always_comb begin
        st = $signed({1'b0, sin_val});
        ct = $signed({1'b0, cos_val});
        case (box.rot_angle[15:14])
            QUAD_0: begin
                s_next = st;
                c_next = ct;
            end
            QUAD_1: begin
                s_next = ct;
                c_next = -st;
            end
            QUAD_2: begin
                s_next = -st;
                c_next = -ct;
            end
            default: begin
                s_next = -ct;
                c_next = st;
            end
        endcase
    end

    always_comb begin
        unique case (box.rot_axis)
            AXIS_X: raw_next = '{a_lo: box.y_low, a_hi: box.y_high, b_lo: box.z_low,
                                 b_hi: box.z_high, t_lo: box.x_low, t_hi: box.x_high};
            AXIS_Y: raw_next = '{a_lo: box.x_low, a_hi: box.x_high, b_lo: box.z_low,
                                 b_hi: box.z_high, t_lo: box.y_low, t_hi: box.y_high};
            default: raw_next = '{a_lo: box.x_low, a_hi: box.x_high, b_lo: box.y_low,
                                  b_hi: box.y_high, t_lo: box.z_low, t_hi: box.z_high};
        endcase
    end

    always_ff @(posedge clk) begin
        if (adv.s2) begin
            axis2_reg <= box.rot_axis;
            c2_reg    <= c_next;
            s2_reg    <= s_next;
            raw2_reg  <= raw_next;
        end
    end

    always_ff @(posedge clk) begin
        if (adv.s3) begin
            axis3_reg <= axis2_reg;
            raw3_reg  <= raw2_reg;
            ca_reg[0] <= 48'(c2_reg) * 48'(raw2_reg.a_lo);
            ca_reg[1] <= 48'(c2_reg) * 48'(raw2_reg.a_hi);
            sa_reg[0] <= 48'(s2_reg) * 48'(raw2_reg.a_lo);
            sa_reg[1] <= 48'(s2_reg) * 48'(raw2_reg.a_hi);
            cb_reg[0] <= 48'(c2_reg) * 48'(raw2_reg.b_lo);
            cb_reg[1] <= 48'(c2_reg) * 48'(raw2_reg.b_hi);
            sb_reg[0] <= 48'(s2_reg) * 48'(raw2_reg.b_lo);
            sb_reg[1] <= 48'(s2_reg) * 48'(raw2_reg.b_hi);
        end
    end

    always_comb begin
        rot_next.axis = axis3_reg;
        rot_next.raw  = raw3_reg;
        for (int bi = 0; bi < 2; bi++) begin
            for (int ai = 0; ai < 2; ai++) begin
                rot_next.na[bi * 2 + ai] = shift_sat(49'(ca_reg[ai]) - 49'(sb_reg[bi]));
                rot_next.nb[bi * 2 + ai] = shift_sat(49'(sa_reg[ai]) + 49'(cb_reg[bi]));
            end
        end
    end

    always_ff @(posedge clk) begin
        if (adv.s4) begin
            rot_reg <= rot_next;
        end
    end

    assign rot = rot_reg;

endmodule

`default_nettype wire

[design/rbb_bounds.sv]
// Final stage: minimum and maximum over the four rotated corners, mapped back to x, y, z
// (AXIS_NONE: box passed through). Registers the result; uses rbb_pkg types, axis codes.
`default_nettype none

module rbb_bounds (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire rbb_pkg::corner_t rot,
    output rbb_pkg::bounds_t      bounds
);
    import rbb_pkg::*;

    function automatic coord_t min4(input coord_t [3:0] v);
        coord_t m0;
        coord_t m1;
        m0 = ($signed(v[0]) < $signed(v[1])) ? v[0] : v[1];
        m1 = ($signed(v[2]) < $signed(v[3])) ? v[2] : v[3];
        return ($signed(m0) < $signed(m1)) ? m0 : m1;
    endfunction

    function automatic coord_t max4(input coord_t [3:0] v);
        coord_t m0;
        coord_t m1;
        m0 = ($signed(v[0]) > $signed(v[1])) ? v[0] : v[1];
        m1 = ($signed(v[2]) > $signed(v[3])) ? v[2] : v[3];
        return ($signed(m0) > $signed(m1)) ? m0 : m1;
    endfunction

    coord_t  a_lo;
    coord_t  a_hi;
    coord_t  b_lo;
    coord_t  b_hi;
    coord_t  t_lo;
    coord_t  t_hi;
    bounds_t bounds_next;
    bounds_t bounds_reg;

    always_comb begin
        a_lo = min4(rot.na);
        a_hi = max4(rot.na);
        b_lo = min4(rot.nb);
        b_hi = max4(rot.nb);
        t_lo = ($signed(rot.raw.t_lo) < $signed(rot.raw.t_hi)) ? rot.raw.t_lo : rot.raw.t_hi;
        t_hi = ($signed(rot.raw.t_lo) > $signed(rot.raw.t_hi)) ? rot.raw.t_lo : rot.raw.t_hi;
        unique case (rot.axis)
            AXIS_X: bounds_next = '{t_lo, t_hi, a_lo, a_hi, b_lo, b_hi};
            AXIS_Y: bounds_next = '{a_lo, a_hi, t_lo, t_hi, b_lo, b_hi};
            AXIS_Z: bounds_next = '{a_lo, a_hi, b_lo, b_hi, t_lo, t_hi};
            default: bounds_next = '{rot.raw.a_lo, rot.raw.a_hi, rot.raw.b_lo,
                                     rot.raw.b_hi, rot.raw.t_lo, rot.raw.t_hi};
        endcase
    end

    always_ff @(posedge clk) begin
        if (en) begin
            bounds_reg <= bounds_next;
        end
    end

    assign bounds = bounds_reg;

endmodule

`default_nettype wire
